// ----- hw/rtl/bfh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bfh_pkg;

    // heap geometry
    localparam int HEAP_WORDS      = 4096;
    localparam int MAX_FREE_BLOCKS = 64;
    localparam int HEADER_WORDS    = 3;

    localparam int ADDR_W = $clog2(HEAP_WORDS);
    localparam int LEN_W  = 13;
    localparam int IDX_W  = $clog2(MAX_FREE_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_FREE_BLOCKS + 1);

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_UNUSED     = 2'd3;

    typedef struct packed {
        logic        command;
        logic [11:0] request_words;
        logic [11:0] payload_address;
    } bfh_in_t;

    typedef struct packed {
        logic [11:0] granted_address;
        logic [1:0]  status;
    } bfh_out_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } bfh_entry_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } bfh_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/best_fit_heap_allocator_unit.sv -----
// channel | direction | handshake        | payload
// in      | into unit | in_valid/in_stall | bfh_in_t: command, request_words, payload_address
// out     | out       | out_valid/out_stall | bfh_out_t: granted_address, status
// cfg     | into unit | cfg_valid/cfg_ready | heap_limit_words, 13 bits
//
// One request at a time. A request walks the free table one entry a cycle
// through the registered table read port. Allocate takes longer when an entry is
// removed; free takes longer when entries move up or one is removed. The table
// holds 64 entries.
// Reset empties the table and zeroes the break pointer at once, no clearing pass.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_heap_allocator_unit
    import bfh_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire bfh_in_t       in_item,
    output logic               out_valid,
    input  wire logic          out_stall,
    output bfh_out_t           out_item,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [12:0]   cfg_data
);

    logic [LEN_W-1:0]  heap_limit_reg;
    logic              out_valid_reg;
    bfh_out_t          out_item_reg;
    bfh_status_t       st;
    bfh_out_t          result;
    logic              start;
    logic              res_ack;

    logic              t_we;
    logic [IDX_W-1:0]  t_wr_addr;
    bfh_entry_t        t_wr_data;
    logic [IDX_W-1:0]  t_rd_addr;
    bfh_entry_t        t_rd_data;
    logic              s_we;
    logic [ADDR_W-1:0] s_wr_addr;
    logic [LEN_W-1:0]  s_wr_data;
    logic [ADDR_W-1:0] s_rd_addr;
    logic [LEN_W-1:0]  s_rd_data;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= LEN_W'(HEAP_WORDS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            heap_limit_reg <= cfg_data;
        end
    end

    // input transfer only while the sequencer is idle
    assign in_stall = !st.idle;
    assign start    = in_valid && !in_stall;

    // output register
    assign res_ack = st.res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    bfh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (in_item),
        .limit     (heap_limit_reg),
        .res_ack   (res_ack),
        .status    (st),
        .result    (result),
        .t_we      (t_we),
        .t_wr_addr (t_wr_addr),
        .t_wr_data (t_wr_data),
        .t_rd_addr (t_rd_addr),
        .t_rd_data (t_rd_data),
        .s_we      (s_we),
        .s_wr_addr (s_wr_addr),
        .s_wr_data (s_wr_data),
        .s_rd_addr (s_rd_addr),
        .s_rd_data (s_rd_data)
    );

    // free table
    bfh_ram #(
        .ADDR_W (IDX_W),
        .DATA_W ($bits(bfh_entry_t))
    ) u_table (
        .clk     (clk),
        .we      (t_we),
        .wr_addr (t_wr_addr),
        .wr_data (t_wr_data),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data)
    );

    // payload length of each granted block
    bfh_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (LEN_W)
    ) u_sizes (
        .clk     (clk),
        .we      (s_we),
        .wr_addr (s_wr_addr),
        .wr_data (s_wr_data),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/bfh_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bfh_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 25
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bfh_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bfh_ctrl
    import bfh_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire bfh_in_t             item,
    input  wire logic [LEN_W-1:0]    limit,
    input  wire logic                res_ack,
    output bfh_status_t              status,
    output bfh_out_t                 result,
    // free table memory
    output logic                     t_we,
    output logic [IDX_W-1:0]         t_wr_addr,
    output bfh_entry_t               t_wr_data,
    output logic [IDX_W-1:0]         t_rd_addr,
    input  wire bfh_entry_t          t_rd_data,
    // block size memory
    output logic                     s_we,
    output logic [ADDR_W-1:0]        s_wr_addr,
    output logic [LEN_W-1:0]         s_wr_data,
    output logic [ADDR_W-1:0]        s_rd_addr,
    input  wire logic [LEN_W-1:0]    s_rd_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ASCAN = 4'd1;
    localparam logic [3:0] S_AFIN  = 4'd2;
    localparam logic [3:0] S_SHDN  = 4'd3;
    localparam logic [3:0] S_FSCAN = 4'd4;
    localparam logic [3:0] S_FFIN  = 4'd5;
    localparam logic [3:0] S_SHUP  = 4'd6;
    localparam logic [3:0] S_SINS  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_FREE_BLOCKS);

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  bp_reg, bp_next;
    logic [11:0]       req_reg, req_next;
    logic [11:0]       pay_reg, pay_next;
    logic [CNT_W-1:0]  ev_reg, ev_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    bfh_entry_t        best_reg, best_next;
    bfh_entry_t        prev_reg, prev_next;
    bfh_entry_t        nxt_reg, nxt_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  sh_reg, sh_next;
    bfh_entry_t        ins_reg, ins_next;
    bfh_out_t          res_reg, res_next;

    // arithmetic shared by the finish states
    logic [ADDR_W-1:0] hdr;
    logic [LEN_W-1:0]  limit_eff;
    logic [13:0]       brk_pay;
    logic [14:0]       brk_end;
    logic [13:0]       split_pay;
    logic [13:0]       whole_pay;
    logic [13:0]       new_end;
    logic [13:0]       prev_end;
    logic [14:0]       sum_n;
    logic [14:0]       sum_p;
    logic [LEN_W-1:0]  len2;
    logic              merge_n;
    logic              merge_p;
    logic [CNT_W-1:0]  ev_inc;

    assign hdr       = pay_reg - ADDR_W'(HEADER_WORDS);
    assign limit_eff = (limit > LEN_W'(HEAP_WORDS)) ? LEN_W'(HEAP_WORDS) : limit;
    assign brk_pay   = {1'b0, bp_reg} + 14'(HEADER_WORDS);
    assign brk_end   = {1'b0, brk_pay} + {3'b0, req_reg};
    assign split_pay = {2'b0, best_reg.start} + {1'b0, best_reg.length}
                     - {2'b0, req_reg} + 14'(HEADER_WORDS);
    assign whole_pay = {2'b0, best_reg.start} + 14'(HEADER_WORDS);
    assign new_end   = {2'b0, hdr} + 14'(HEADER_WORDS) + {1'b0, s_rd_data};
    assign prev_end  = {2'b0, prev_reg.start} + 14'(HEADER_WORDS)
                     + {1'b0, prev_reg.length};
    assign merge_n   = (pos_reg < count_reg) && (new_end == {2'b0, nxt_reg.start});
    assign merge_p   = (pos_reg != '0) && (prev_end == {2'b0, hdr});
    assign sum_n     = {2'b0, s_rd_data} + 15'(HEADER_WORDS) + {2'b0, nxt_reg.length};
    assign len2      = !merge_n ? s_rd_data
                     : (sum_n > {2'b0, LEN_MAX}) ? LEN_MAX : sum_n[LEN_W-1:0];
    assign sum_p     = {2'b0, prev_reg.length} + 15'(HEADER_WORDS) + {2'b0, len2};
    assign ev_inc    = ev_reg + 1'b1;

    // size memory address follows the request from the accept cycle on
    assign s_rd_addr = start ? item.payload_address : pay_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        bp_next       = bp_reg;
        req_next      = req_reg;
        pay_next      = pay_reg;
        ev_next       = ev_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        pos_next      = pos_reg;
        sh_next       = sh_reg;
        ins_next      = ins_reg;
        res_next      = res_reg;
        t_we          = 1'b0;
        t_wr_addr     = '0;
        t_wr_data     = '0;
        t_rd_addr     = '0;
        s_we          = 1'b0;
        s_wr_addr     = '0;
        s_wr_data     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = item.request_words;
                    pay_next   = item.payload_address;
                    ev_next    = '0;
                    found_next = 1'b0;
                    pos_next   = '0;
                    res_next   = '{granted_address: '0, status: ST_OK};
                    if (item.command == CMD_ALLOC)
                    begin
                        state_next = (count_reg == '0) ? S_AFIN : S_ASCAN;
                    end
                    else if (item.payload_address < 12'(HEADER_WORDS))
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg == CNT_FULL)
                    begin
                        res_next.status = ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? S_FFIN : S_FSCAN;
                    end
                end
            end

            // best fit search, one entry a cycle
            S_ASCAN:
            begin
                t_rd_addr = ev_inc[IDX_W-1:0];
                ev_next   = ev_inc;
                if (ev_inc == count_reg)
                begin
                    state_next = S_AFIN;
                end
                if (t_rd_data.length >= {1'b0, req_reg} &&
                    (!found_reg || t_rd_data.length < best_reg.length))
                begin
                    found_next    = 1'b1;
                    best_idx_next = ev_reg[IDX_W-1:0];
                    best_next     = t_rd_data;
                    if (t_rd_data.length == {1'b0, req_reg})
                    begin
                        state_next = S_AFIN;
                    end
                end
            end

            S_AFIN:
            begin
                state_next = S_DONE;
                if (!found_reg)
                begin
                    if (brk_end > {2'b0, limit_eff} || brk_pay >= 14'(HEAP_WORDS))
                    begin
                        res_next.status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        s_we      = 1'b1;
                        s_wr_addr = brk_pay[ADDR_W-1:0];
                        s_wr_data = {1'b0, req_reg};
                        bp_next   = brk_end[LEN_W-1:0];
                        res_next.granted_address = brk_pay[11:0];
                    end
                end
                else if (best_reg.length < {1'b0, req_reg} + LEN_W'(HEADER_WORDS))
                begin
                    // whole block, then close the gap in the table
                    s_we      = (whole_pay < 14'(HEAP_WORDS));
                    s_wr_addr = whole_pay[ADDR_W-1:0];
                    s_wr_data = best_reg.length;
                    res_next.granted_address = whole_pay[11:0];
                    if ({1'b0, best_idx_reg} + 1'b1 == count_reg)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        t_rd_addr  = best_idx_reg + 1'b1;
                        sh_next    = {1'b0, best_idx_reg};
                        state_next = S_SHDN;
                    end
                end
                else
                begin
                    // split off the tail
                    t_we      = 1'b1;
                    t_wr_addr = best_idx_reg;
                    t_wr_data = '{start: best_reg.start,
                                  length: best_reg.length - LEN_W'(HEADER_WORDS)
                                          - {1'b0, req_reg}};
                    s_we      = (split_pay < 14'(HEAP_WORDS));
                    s_wr_addr = split_pay[ADDR_W-1:0];
                    s_wr_data = {1'b0, req_reg};
                    res_next.granted_address = split_pay[11:0];
                end
            end

            // remove one entry: move the tail down by one
            S_SHDN:
            begin
                t_we      = 1'b1;
                t_wr_addr = sh_reg[IDX_W-1:0];
                t_wr_data = t_rd_data;
                t_rd_addr = IDX_W'(sh_reg + 2'd2);
                if (sh_reg + 2'd2 == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    sh_next = sh_reg + 1'b1;
                end
            end

            // insertion point search
            S_FSCAN:
            begin
                if (t_rd_data.start <= hdr)
                begin
                    prev_next = t_rd_data;
                    pos_next  = ev_inc;
                    t_rd_addr = ev_inc[IDX_W-1:0];
                    ev_next   = ev_inc;
                    if (ev_inc == count_reg)
                    begin
                        state_next = S_FFIN;
                    end
                end
                else
                begin
                    nxt_next   = t_rd_data;
                    pos_next   = ev_reg;
                    state_next = S_FFIN;
                end
            end

            S_FFIN:
            begin
                state_next = S_DONE;
                ins_next   = '{start: hdr, length: s_rd_data};
                priority if (merge_p)
                begin
                    t_we      = 1'b1;
                    t_wr_addr = IDX_W'(pos_reg - 1'b1);
                    t_wr_data = '{start: prev_reg.start,
                                  length: (sum_p > {2'b0, LEN_MAX}) ? LEN_MAX
                                          : sum_p[LEN_W-1:0]};
                    if (merge_n)
                    begin
                        if (pos_reg + 1'b1 == count_reg)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            t_rd_addr  = IDX_W'(pos_reg + 1'b1);
                            sh_next    = pos_reg;
                            state_next = S_SHDN;
                        end
                    end
                end
                else if (merge_n)
                begin
                    t_we      = 1'b1;
                    t_wr_addr = pos_reg[IDX_W-1:0];
                    t_wr_data = '{start: hdr, length: len2};
                end
                else if (pos_reg == count_reg)
                begin
                    t_we       = 1'b1;
                    t_wr_addr  = pos_reg[IDX_W-1:0];
                    t_wr_data  = '{start: hdr, length: s_rd_data};
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    t_rd_addr  = IDX_W'(count_reg - 1'b1);
                    sh_next    = count_reg;
                    state_next = S_SHUP;
                end
            end

            // open a slot: move the tail up by one
            S_SHUP:
            begin
                t_we      = 1'b1;
                t_wr_addr = sh_reg[IDX_W-1:0];
                t_wr_data = t_rd_data;
                t_rd_addr = IDX_W'(sh_reg - 2'd2);
                if (sh_reg - 1'b1 == pos_reg)
                begin
                    state_next = S_SINS;
                end
                else
                begin
                    sh_next = sh_reg - 1'b1;
                end
            end

            S_SINS:
            begin
                t_we       = 1'b1;
                t_wr_addr  = pos_reg[IDX_W-1:0];
                t_wr_data  = ins_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bp_reg    <= bp_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pay_reg      <= pay_next;
        ev_reg       <= ev_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        pos_reg      <= pos_next;
        sh_reg       <= sh_next;
        ins_reg      <= ins_next;
        res_reg      <= res_next;
    end

    assign status.idle      = (state_reg == S_IDLE);
    assign status.res_valid = (state_reg == S_DONE);
    assign result           = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bfh_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bfh_checker
    import bfh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_stall,
    input  wire logic     out_valid,
    input  wire logic     out_stall,
    input  wire bfh_out_t out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // one request at a time: a transfer closes the input
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transfer");

    // status code three is never produced
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status != ST_UNUSED)
        else $error("bad status code");

    // failed requests grant nothing
    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK |-> out_item.granted_address == '0)
        else $error("address granted with error status");

endmodule

bind best_fit_heap_allocator_unit bfh_checker u_bfh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import bfh_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    bfh_in_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    bfh_out_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [12:0] cfg_data = '0;

    best_fit_heap_allocator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // clock
    always #2 clk = ~clk;

    // allocator shadow state
    logic [12:0] lim_words;
    logic [11:0] fl_start [MAX_FREE_BLOCKS];
    logic [12:0] fl_len [MAX_FREE_BLOCKS];
    int fl_count;
    int brk;
    logic [12:0] size_of [HEAP_WORDS];
    bit size_known [HEAP_WORDS];
    // payload addresses currently live (allocated, not freed)
    int live_q[$];

    bfh_out_t grant_q[$];
    int errors = 0;
    bit quiet_out = 1'b0;
    bit no_idle = 1'b0;
    int hold_cycles = 0;

    task automatic fl_remove(input int i);
        for (int k = i; k + 1 < fl_count; k++)
        begin
            fl_start[k] = fl_start[k+1];
            fl_len[k] = fl_len[k+1];
        end
        fl_count--;
    endtask

    function automatic logic [12:0] sat13(input int v);
        return (v > 8191) ? 13'd8191 : v[12:0];
    endfunction

    // compute the allocator's answer and advance the shadow state
    task automatic predict_heap(input bfh_in_t it, output bfh_out_t r);
        int best, found, req, pay, lim, st, len, hdr, pos;
        best = 0;
        found = 0;
        r = '0;
        if (it.command == CMD_ALLOC)
        begin
            req = it.request_words;
            for (int i = 0; i < fl_count; i++)
            begin
                if (fl_len[i] >= req && (!found || fl_len[i] < fl_len[best]))
                begin
                    best = i;
                    found = 1;
                    if (fl_len[i] == req) break;
                end
            end
            if (!found)
            begin
                lim = (lim_words < HEAP_WORDS) ? lim_words : HEAP_WORDS;
                pay = brk + HEADER_WORDS;
                if (pay + req > lim || pay >= HEAP_WORDS)
                    r.status = ST_EXHAUSTED;
                else
                begin
                    size_of[pay] = req[12:0];
                    size_known[pay] = 1'b1;
                    brk = pay + req;
                    r.granted_address = pay[11:0];
                    r.status = ST_OK;
                    live_q.push_back(pay);
                end
            end
            else
            begin
                st = fl_start[best];
                len = fl_len[best];
                if (len < req + HEADER_WORDS)
                begin
                    pay = st + HEADER_WORDS;
                    fl_remove(best);
                    if (pay < HEAP_WORDS) size_of[pay] = len[12:0];
                end
                else
                begin
                    pay = st + len - req + HEADER_WORDS;
                    fl_len[best] = 13'(len - HEADER_WORDS - req);
                    if (pay < HEAP_WORDS) size_of[pay] = req[12:0];
                end
                if (pay < HEAP_WORDS)
                begin
                    size_known[pay] = 1'b1;
                    live_q.push_back(pay);
                end
                r.granted_address = pay[11:0];
            end
        end
        else
        begin
            pay = it.payload_address;
            if (pay < HEADER_WORDS || pay >= HEAP_WORDS) return;
            if (fl_count >= MAX_FREE_BLOCKS)
            begin
                r.status = ST_TABLE_FULL;
                return;
            end
            hdr = pay - HEADER_WORDS;
            pos = 0;
            while (pos < fl_count && fl_start[pos] <= hdr) pos++;
            for (int k = fl_count; k > pos; k--)
            begin
                fl_start[k] = fl_start[k-1];
                fl_len[k] = fl_len[k-1];
            end
            fl_start[pos] = hdr[11:0];
            fl_len[pos] = size_of[pay];
            fl_count++;
            if (pos + 1 < fl_count && hdr + HEADER_WORDS + fl_len[pos] == fl_start[pos+1])
            begin
                fl_len[pos] = sat13(fl_len[pos] + HEADER_WORDS + fl_len[pos+1]);
                fl_remove(pos + 1);
            end
            if (pos > 0 && fl_start[pos-1] + HEADER_WORDS + fl_len[pos-1] == hdr)
            begin
                fl_len[pos-1] = sat13(fl_len[pos-1] + HEADER_WORDS + fl_len[pos]);
                fl_remove(pos);
            end
        end
    endtask

    // one request transfer; fixed is set where the answer is typed in
    task automatic send_req(input bfh_in_t it, input bit fixed, input bfh_out_t want);
        bfh_out_t r;
        while (!no_idle && $urandom_range(99) < 7)
            @(posedge clk);
        predict_heap(it, r);
        if (fixed && r !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch: table %h predictor %h", want, r);
        end
        grant_q.push_back(r);
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic write_limit(input logic [12:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        lim_words = v;
    endtask

    function automatic bfh_in_t mk(input logic c, input int rq, input int pa);
        bfh_in_t t;
        t.command = c;
        t.request_words = rq[11:0];
        t.payload_address = pa[11:0];
        return t;
    endfunction

    // random op: a stray command or free, a free of a live block, else allocate
    task automatic random_op(input int max_req);
        int j;
        bfh_in_t it;
        int sel;
        sel = $urandom_range(99);
        if (sel < 3)
            it = mk(1'($urandom), $urandom, $urandom_range(2));
        else if (sel < 5)
            it = mk(CMD_FREE, $urandom, 4095 - $urandom_range(0) );
        else if (live_q.size() != 0 && sel < 50)
        begin
            j = $urandom_range(live_q.size() - 1);
            it = mk(CMD_FREE, $urandom, live_q[j]);
            live_q.delete(j);
        end
        else
            it = mk(CMD_ALLOC, $urandom_range(max_req), $urandom);
        // freeing a never-sized address is not allowed
        if (it.command == CMD_FREE && it.payload_address >= HEADER_WORDS &&
            !size_known[it.payload_address])
            it.command = CMD_ALLOC;
        send_req(it, 1'b0, '0);
    endtask

    // directed stimulus table
    typedef struct {
        bfh_in_t it;
        bit fixed;
        bfh_out_t want;
    } row_t;

    initial
    begin
        row_t rows[$];
        bfh_out_t ok0;
        ok0 = '0;
        lim_words = 13'd4096;
        fl_count = 0;
        brk = 0;
        for (int i = 0; i < HEAP_WORDS; i++)
        begin
            size_of[i] = '0;
            size_known[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_limit(13'd8191);
        rows.push_back('{mk(CMD_ALLOC, 0, 4095), 1'b1, '{12'd3, ST_OK}});
        rows.push_back('{mk(CMD_ALLOC, 10, 0), 1'b1, '{12'd6, ST_OK}});
        rows.push_back('{mk(CMD_ALLOC, 4095, 0), 1'b1, '{12'd0, ST_EXHAUSTED}});
        rows.push_back('{mk(CMD_FREE, 0, 0), 1'b1, ok0});
        rows.push_back('{mk(CMD_FREE, 0, 2), 1'b1, ok0});
        rows.push_back('{mk(CMD_FREE, 4095, 6), 1'b1, ok0});
        rows.push_back('{mk(CMD_ALLOC, 10, 0), 1'b0, ok0});
        rows.push_back('{mk(CMD_ALLOC, 40, 0), 1'b0, ok0});
        rows.push_back('{mk(CMD_ALLOC, 20, 0), 1'b0, ok0});
        foreach (rows[i])
            send_req(rows[i].it, rows[i].fixed, rows[i].want);
        rows.delete();
        drain_results();

        // exhaustion with a zero limit
        write_limit(13'd0);
        send_req(mk(CMD_ALLOC, 4095, 0), 1'b1, '{12'd0, ST_EXHAUSTED});
        drain_results();
        write_limit(13'd4096);

        // random phases with different limits
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
                no_idle = 1'b1;
            else
                no_idle = 1'b0;
            for (int n = 0; n < 200; n++)
                random_op((ph == 4) ? 4095 : 60);
            drain_results();
            write_limit((ph == 3) ? 13'd4096 : 13'($urandom_range(8191)));
        end

        // many small blocks freed apart to fill the free table
        write_limit(13'd8191);
        for (int n = 0; n < 150; n++)
        begin
            if (n % 2 == 0 || live_q.size() == 0)
                send_req(mk(CMD_ALLOC, $urandom_range(3), 0), 1'b0, '0);
            else
            begin
                send_req(mk(CMD_FREE, 0, live_q[0]), 1'b0, '0);
                void'(live_q.pop_front());
                if (live_q.size() != 0) void'(live_q.pop_front());
            end
        end
        drain_results();
        for (int n = 0; n < 100; n++)
            random_op(8);
        drain_results();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver stall: random, plus one long hold-off
    initial
    begin
        int cyc;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_cycles == 0 && cyc > 3000 && grant_q.size() != 0 && !quiet_out)
            begin
                hold_cycles = 400;
                quiet_out = 1'b1;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (!no_idle && $urandom_range(99) < 7);
        end
    end

    // check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        bfh_out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (grant_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", out_item);
            end
            else
            begin
                exp_r = grant_q.pop_front();
                if (out_item.granted_address !== exp_r.granted_address ||
                    out_item.status !== exp_r.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp addr %0d st %0d, got addr %0d st %0d",
                            exp_r.granted_address, exp_r.status,
                            out_item.granted_address, out_item.status);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
